FILE: rtl/sxb_pkg.sv
package sxb_pkg;

    // request function codes
    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_ACK   = 2'd3;

    // fixed-point reciprocal used for the origin wrap
    localparam int FRAC_BITS = 16;
    localparam int RECIP_W   = 17;
    localparam int PROD_W    = 8 + RECIP_W;

    // frame rows are always stored 64 pixels wide
    localparam int LINE_W = 64;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [3:0] row_index;
        logic [7:0] sprite_bits;
        logic       first_row;
        logic       last_row;
        logic [4:0] read_line;
    } t_req;

    typedef struct packed {
        logic              collision;
        logic              redraw_pending;
        logic [LINE_W-1:0] line_pixels;
        logic              sprite_done;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUOT,
        ST_MOD,
        ST_READ,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic quot;
        logic modr;
        logic rd;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_sts;

endpackage

FILE: rtl/sxb_stream_if.sv
interface sxb_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sxb_ctrl.sv
module sxb_ctrl
    import sxb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_QUOT;
                end
            end
            ST_QUOT: n_state = ST_MOD;
            ST_MOD:  n_state = ST_READ;
            ST_READ: n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = !i_sts.out_full;
                o_cmd.load = i_in_valid && !i_sts.out_full;
            end
            ST_QUOT: o_cmd.quot = 1'b1;
            ST_MOD:  o_cmd.modr = 1'b1;
            ST_READ: o_cmd.rd   = 1'b1;
            ST_EXEC: o_cmd.exec = 1'b1;
            default: o_cmd      = '0;
        endcase
    end

endmodule

FILE: rtl/sxb_datapath.sv
module sxb_datapath
    import sxb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_req i_in_data,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_rsp o_out_data,
    output t_sts o_sts
);

    localparam int ROW_W   = $clog2(SCREEN_HEIGHT);
    localparam int SUM_W   = $clog2(SCREEN_HEIGHT + 15);
    localparam int RECIP_X = ((1 << FRAC_BITS) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
    localparam int RECIP_Y = ((1 << FRAC_BITS) + SCREEN_HEIGHT - 1) / SCREEN_HEIGHT;
    localparam logic [7:0]        WIDTH_8  = 8'(SCREEN_WIDTH);
    localparam logic [7:0]        HEIGHT_8 = 8'(SCREEN_HEIGHT);
    localparam logic [SUM_W-1:0]  HEIGHT_S = SUM_W'(SCREEN_HEIGHT);
    localparam logic [LINE_W-1:0] COL_MASK = {LINE_W{1'b1}} << (LINE_W - SCREEN_WIDTH);

    t_req               r_req;
    logic [7:0]         r_qx;
    logic [7:0]         r_qy;
    logic [5:0]         r_xm;
    logic [SUM_W-1:0]   r_row;
    logic [ROW_W-1:0]   r_addr;
    logic               r_in_range;
    logic [LINE_W-1:0]  r_rd_data;
    logic               r_rd_vld;
    logic [LINE_W-1:0]  r_mem [SCREEN_HEIGHT];
    logic [SCREEN_HEIGHT-1:0] r_row_valid;
    logic               r_collision;
    logic               r_redraw;
    logic               r_out_valid;
    t_rsp               r_rsp;

    logic [PROD_W-1:0]  w_prod_x;
    logic [PROD_W-1:0]  w_prod_y;
    logic [7:0]         w_xm;
    logic [7:0]         w_ym;
    logic [SUM_W-1:0]   w_sel;
    logic [LINE_W-1:0]  w_cur;
    logic [LINE_W-1:0]  w_pattern;
    logic               w_hit;
    logic               w_draw_on;
    logic               n_collision;
    logic               n_redraw;
    t_rsp               n_rsp;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_data;
        end
    end

    // origin wrap: quotient by reciprocal multiply
    assign w_prod_x = PROD_W'(r_req.x_pos) * PROD_W'(RECIP_X);
    assign w_prod_y = PROD_W'(r_req.y_pos) * PROD_W'(RECIP_Y);

    always_ff @(posedge i_clk) begin
        if (i_cmd.quot) begin
            r_qx <= 8'(w_prod_x >> FRAC_BITS);
            r_qy <= 8'(w_prod_y >> FRAC_BITS);
        end
    end

    // origin wrap: remainder and target row
    assign w_xm = r_req.x_pos - 8'(r_qx * WIDTH_8);
    assign w_ym = r_req.y_pos - 8'(r_qy * HEIGHT_8);

    always_ff @(posedge i_clk) begin
        if (i_cmd.modr) begin
            r_xm  <= w_xm[5:0];
            r_row <= SUM_W'(w_ym) + SUM_W'(r_req.row_index);
        end
    end

    // frame row read
    assign w_sel = (r_req.func == FUNC_DRAW) ? r_row : SUM_W'(r_req.read_line);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_addr     <= w_sel[ROW_W-1:0];
            r_in_range <= w_sel < HEIGHT_S;
            r_rd_data  <= r_mem[w_sel[ROW_W-1:0]];
            r_rd_vld   <= r_row_valid[w_sel[ROW_W-1:0]];
        end
    end

    // rows never written since the last clear read as blank
    assign w_cur     = r_rd_vld ? r_rd_data : '0;
    assign w_pattern = ({r_req.sprite_bits, 56'd0} >> r_xm) & COL_MASK;
    assign w_hit     = (w_cur & w_pattern) != '0;
    assign w_draw_on = (r_req.func == FUNC_DRAW) && r_in_range;

    // frame row write back
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_draw_on) begin
            r_mem[r_addr] <= w_cur ^ w_pattern;
        end
    end

    // flag update and result assembly
    always_comb begin
        n_collision = r_collision;
        n_redraw    = r_redraw;
        n_rsp       = '0;
        case (r_req.func)
            FUNC_DRAW: begin
                if (r_req.first_row) begin
                    n_collision = 1'b0;
                end
                if (r_in_range) begin
                    n_collision = n_collision | w_hit;
                    n_redraw    = 1'b1;
                end
                n_rsp.sprite_done = r_req.last_row;
            end
            FUNC_READ: begin
                if (r_in_range) begin
                    n_rsp.line_pixels = w_cur & COL_MASK;
                end
            end
            FUNC_ACK: n_redraw = 1'b0;
            default: n_rsp = '0;
        endcase
        n_rsp.collision      = n_collision;
        n_rsp.redraw_pending = n_redraw;
    end

    // control state: flags, row valid bits, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collision <= 1'b0;
            r_redraw    <= 1'b0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.exec) begin
                r_collision <= n_collision;
                r_redraw    <= n_redraw;
                r_out_valid <= 1'b1;
                if (r_req.func == FUNC_CLEAR) begin
                    r_row_valid <= '0;
                end else if (w_draw_on) begin
                    r_row_valid[r_addr] <= 1'b1;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_rsp;
    assign o_sts.out_full = r_out_valid;

endmodule

FILE: rtl/sprite_xor_blitter_top.sv
// One-bit sprite blitter with a SCREEN_WIDTH x SCREEN_HEIGHT frame store. Each request
// draws one 8-pixel sprite row with XOR (clipped at the right and bottom edges, origin
// wrapped to the screen), clears the screen, reads one frame row, or acknowledges a
// redraw, and returns exactly one response carrying the collision and redraw-pending
// flags. The request is captured at acceptance, and the response is valid once these
// steps are done: reciprocal multiply for the origin wrap, remainder and row add,
// registered frame memory read, then the read-modify-write and flag update. The frame
// memory has a single port, so one request is in flight at a time; a new request is
// taken the cycle after the response register empties. Clear screen resets the per-row
// valid bits rather than the frame memory, so there is no clearing pass after reset.
module sprite_xor_blitter_top
    import sxb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sxb_stream_if.sink   i_req,
    sxb_stream_if.source o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;
    t_req w_req_data;
    t_rsp w_rsp_data;

    assign w_req_data = i_req.data;
    assign o_rsp.data = w_rsp_data;

    // sequencer
    sxb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (w_sts),
        .o_in_ready (i_req.ready),
        .o_cmd      (w_cmd)
    );

    // frame store and flag datapath
    sxb_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_data   (w_req_data),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_out_data  (w_rsp_data),
        .o_sts       (w_sts)
    );

endmodule

FILE: tb/sv/tb_sprite_xor_blitter_top.sv
module tb_sprite_xor_blitter_top
    import sxb_pkg::*;
;

    localparam int SCR_W        = 64;
    localparam int SCR_H        = 32;
    localparam int CLK_HALF     = 5;
    localparam int DIR_ROWS     = 24;
    localparam int RAND_ITEMS   = 1600;
    localparam int CALM_ITEMS   = 150;
    localparam int LONG_HOLD_AT = 500;
    localparam int LONG_HOLD    = 200;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 400_000;

    localparam logic [LINE_W-1:0] COL_MASK = ~{LINE_W{1'b0}} << (LINE_W - SCR_W);

    // directed row: request plus an optional hand-written response
    typedef struct packed {
        t_req rq;
        logic gold_given;
        t_rsp gold;
    } t_dir_row;

    typedef struct {
        t_req rq;
        bit   gold_given;
        t_rsp gold;
        bit   hold_until_empty;
    } t_blit_item;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sxb_stream_if #(.T(t_req)) req_if ();
    sxb_stream_if #(.T(t_rsp)) rsp_if ();

    sprite_xor_blitter_top #(
        .SCREEN_WIDTH (SCR_W),
        .SCREEN_HEIGHT(SCR_H)
    ) i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // frame image and flags as the block should hold them
    logic [LINE_W-1:0] frame_img [SCR_H];
    logic              coll_flag;
    logic              redraw_flag;

    t_dir_row   dir_tbl [DIR_ROWS];
    t_blit_item blit_plan [$];
    t_rsp       due_rsps [$];

    int mismatch_cnt = 0;
    int rsp_count    = 0;
    int cycle_cnt    = 0;
    int idle_pct     = 0;
    int hold_left    = 0;
    bit long_hold_done = 1'b0;
    bit calm           = 1'b0;

    always #CLK_HALF clk = ~clk;

    // apply one request to the frame image and return the response it causes
    function automatic t_rsp blit_predict(input t_req rq);
        t_rsp              rs;
        int                col;
        int                row;
        logic [LINE_W-1:0] pat;
        rs  = '0;
        col = rq.x_pos % SCR_W;
        row = rq.y_pos % SCR_H + rq.row_index;
        case (rq.func)
            FUNC_DRAW: begin
                if (rq.first_row) coll_flag = 1'b0;
                // rows below the screen are dropped, no wrap
                if (row < SCR_H) begin
                    pat = ({rq.sprite_bits, {(LINE_W - 8){1'b0}}} >> col) & COL_MASK;
                    if ((frame_img[row] & pat) != '0) coll_flag = 1'b1;
                    frame_img[row] = frame_img[row] ^ pat;
                    redraw_flag = 1'b1;
                end
                rs.sprite_done = rq.last_row;
            end
            FUNC_CLEAR: begin
                foreach (frame_img[i]) frame_img[i] = '0;
            end
            FUNC_READ: begin
                if (rq.read_line < SCR_H) rs.line_pixels = frame_img[rq.read_line] & COL_MASK;
            end
            FUNC_ACK: begin
                redraw_flag = 1'b0;
            end
        endcase
        rs.collision      = coll_flag;
        rs.redraw_pending = redraw_flag;
        return rs;
    endfunction

    // cycle limit
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d responses outstanding", $time, due_rsps.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // idling intensity is picked anew at random, zero half of the time
    always @(posedge clk) begin
        if ((cycle_cnt % 64) == 0) begin
            case ($urandom_range(3))
                0, 1: idle_pct <= 0;
                2: idle_pct <= 10;
                default: idle_pct <= 35;
            endcase
        end
    end

    // response side: random stall bursts plus one long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            rsp_if.ready <= 1'b0;
        end else if (!long_hold_done && !calm && rsp_count >= LONG_HOLD_AT) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD - 1;
            rsp_if.ready   <= 1'b0;
        end else if (!calm && $urandom_range(99) < idle_pct) begin
            hold_left    <= $urandom_range(17);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // compare each response with the oldest expectation
    always @(posedge clk) begin : rsp_check
        t_rsp want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            rsp_count <= rsp_count + 1;
            if (due_rsps.size() == 0) begin
                $display("%0t: unexpected response, expected none, got %h", $time, rsp_if.data);
                mismatch_cnt++;
            end else begin
                want = due_rsps.pop_front();
                if (rsp_if.data.collision !== want.collision) begin
                    $display("%0t: collision expected %b got %b", $time,
                             want.collision, rsp_if.data.collision);
                    mismatch_cnt++;
                end
                if (rsp_if.data.redraw_pending !== want.redraw_pending) begin
                    $display("%0t: redraw_pending expected %b got %b", $time,
                             want.redraw_pending, rsp_if.data.redraw_pending);
                    mismatch_cnt++;
                end
                if (rsp_if.data.line_pixels !== want.line_pixels) begin
                    $display("%0t: line_pixels expected %h got %h", $time,
                             want.line_pixels, rsp_if.data.line_pixels);
                    mismatch_cnt++;
                end
                if (rsp_if.data.sprite_done !== want.sprite_done) begin
                    $display("%0t: sprite_done expected %b got %b", $time,
                             want.sprite_done, rsp_if.data.sprite_done);
                    mismatch_cnt++;
                end
            end
        end
    end

    // request side: build the plan, reset, send, wait for the tail
    initial begin
        t_blit_item it;
        t_rsp       rsp;
        int         idx;
        int         gap;
        int         pick;
        int         n;
        int         k;
        int         sx;
        int         sy;
        int         nreads;

        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        foreach (frame_img[i]) frame_img[i] = '0;
        coll_flag   = 1'b0;
        redraw_flag = 1'b0;

        // func, x, y, row, bits, first, last, line | typed | coll, redraw, line, done
        dir_tbl = '{
            // reads right after reset see a dark screen
            '{'{FUNC_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 1'b0, 5'd0 }, 1'b1,
              '{1'b0, 1'b0, 64'h0, 1'b0}},
            '{'{FUNC_READ,  8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1, 1'b1, 5'd31}, 1'b1,
              '{1'b0, 1'b0, 64'h0, 1'b0}},
            // full byte at the origin, then the same byte again to collide
            '{'{FUNC_DRAW,  8'h00, 8'h00, 4'h0, 8'hFF, 1'b1, 1'b1, 5'd0 }, 1'b1,
              '{1'b0, 1'b1, 64'h0, 1'b1}},
            '{'{FUNC_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 1'b0, 5'd0 }, 1'b1,
              '{1'b0, 1'b1, 64'hFF00_0000_0000_0000, 1'b0}},
            '{'{FUNC_DRAW,  8'h00, 8'h00, 4'h0, 8'hFF, 1'b1, 1'b1, 5'd0 }, 1'b1,
              '{1'b1, 1'b1, 64'h0, 1'b1}},
            '{'{FUNC_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 1'b0, 5'd0 }, 1'b1,
              '{1'b1, 1'b1, 64'h0, 1'b0}},
            '{'{FUNC_ACK,   8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 1'b0, 5'd0 }, 1'b1,
              '{1'b1, 1'b0, 64'h0, 1'b0}},
            // right edge clip on the bottom row
            '{'{FUNC_DRAW,  8'd60, 8'hFF, 4'h0, 8'hFF, 1'b1, 1'b0, 5'd0 }, 1'b0, '0},
            '{'{FUNC_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 1'b0, 5'd31}, 1'b0, '0},
            // row below the screen
            '{'{FUNC_DRAW,  8'hFF, 8'h1F, 4'h1, 8'hAA, 1'b0, 1'b1, 5'd0 }, 1'b0, '0},
            '{'{FUNC_ACK,   8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 1'b0, 5'd0 }, 1'b0, '0},
            '{'{FUNC_DRAW,  8'd60, 8'd31, 4'h0, 8'h80, 1'b0, 1'b0, 5'd0 }, 1'b0, '0},
            '{'{FUNC_ACK,   8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 1'b0, 5'd0 }, 1'b0, '0},
            // clipped first row still clears collision
            '{'{FUNC_DRAW,  8'h00, 8'd20, 4'hE, 8'hFF, 1'b1, 1'b1, 5'd0 }, 1'b0, '0},
            // empty row on screen still raises redraw
            '{'{FUNC_DRAW,  8'd10, 8'd5,  4'h3, 8'h00, 1'b1, 1'b1, 5'd0 }, 1'b0, '0},
            '{'{FUNC_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 1'b0, 5'd8 }, 1'b0, '0},
            // origin wrap by the screen size, highest row index
            '{'{FUNC_DRAW,  8'h80, 8'h20, 4'hF, 8'h55, 1'b1, 1'b0, 5'd0 }, 1'b0, '0},
            '{'{FUNC_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 1'b0, 5'd15}, 1'b0, '0},
            '{'{FUNC_DRAW,  8'h3F, 8'hE0, 4'h0, 8'hC3, 1'b0, 1'b1, 5'd0 }, 1'b0, '0},
            '{'{FUNC_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 1'b0, 5'd0 }, 1'b0, '0},
            // clear keeps flags, other fields ignored
            '{'{FUNC_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1, 1'b1, 5'd31}, 1'b0, '0},
            '{'{FUNC_READ,  8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1, 1'b1, 5'd15}, 1'b0, '0},
            '{'{FUNC_ACK,   8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1, 1'b1, 5'd31}, 1'b0, '0},
            '{'{FUNC_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 1'b0, 5'd0 }, 1'b0, '0}
        };

        foreach (dir_tbl[i]) begin
            it.rq               = dir_tbl[i].rq;
            it.gold_given       = dir_tbl[i].gold_given;
            it.gold             = dir_tbl[i].gold;
            it.hold_until_empty = 1'b0;
            blit_plan.push_back(it);
        end

        // random part: mostly whole sprites, with reads of the rows just drawn
        it.gold_given = 1'b0;
        it.gold       = '0;
        while (blit_plan.size() < DIR_ROWS + RAND_ITEMS) begin
            pick = $urandom_range(99);
            it.hold_until_empty = (blit_plan.size() == DIR_ROWS) || ($urandom_range(199) == 0);
            if (pick < 65) begin
                n  = $urandom_range(1, 15);
                sx = $urandom_range(255);
                sy = $urandom_range(255);
                // lean toward the right edge a third of the time
                if ($urandom_range(2) == 0) sx = (sx & 8'hC0) | $urandom_range(56, 63);
                for (k = 0; k < n; k++) begin
                    it.rq = '{FUNC_DRAW, sx[7:0], sy[7:0], k[3:0], 8'($urandom_range(255)),
                              k == 0, k == n - 1, 5'($urandom)};
                    blit_plan.push_back(it);
                    it.hold_until_empty = 1'b0;
                end
                if ($urandom_range(1) == 0) begin
                    nreads = $urandom_range(1, 4);
                    for (k = 0; k < nreads; k++) begin
                        it.rq           = 37'({$urandom, $urandom});
                        it.rq.func      = FUNC_READ;
                        it.rq.read_line = 5'((sy % SCR_H) + $urandom_range(n - 1));
                        blit_plan.push_back(it);
                    end
                end
            end else begin
                it.rq = 37'({$urandom, $urandom});
                if (pick < 83)      it.rq.func = FUNC_READ;
                else if (pick < 85) it.rq.func = FUNC_CLEAR;
                else if (pick < 91) it.rq.func = FUNC_ACK;
                else if (pick < 96) it.rq.func = FUNC_DRAW;
                blit_plan.push_back(it);
            end
        end

        // reset
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (idx = 0; idx < blit_plan.size(); idx++) begin
            gap = 0;
            if (idx >= blit_plan.size() - CALM_ITEMS) calm <= 1'b1;
            else if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 18);
            if (blit_plan[idx].hold_until_empty || gap != 0) req_if.valid <= 1'b0;
            if (blit_plan[idx].hold_until_empty) begin
                do @(posedge clk); while (due_rsps.size() != 0);
            end
            repeat (gap) @(posedge clk);
            req_if.valid <= 1'b1;
            req_if.data  <= blit_plan[idx].rq;
            do @(posedge clk); while (!(req_if.valid && req_if.ready));
            // request taken at this edge
            rsp = blit_predict(blit_plan[idx].rq);
            due_rsps.push_back(blit_plan[idx].gold_given ? blit_plan[idx].gold : rsp);
        end
        req_if.valid <= 1'b0;

        while (due_rsps.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
